@@ rtl/hst_pkg.sv @@
// hst_pkg: shared types and constants for the hashed session table.
// Holds command/status codes, default sizes and controller-datapath structs.
// No dependencies.
package hst_pkg;

  localparam int DEF_BUCKETS = 8;
  localparam int DEF_WAYS    = 4;

  localparam int ID_W      = 32;
  localparam int CMD_W     = 2;
  localparam int STAT_W    = 2;
  localparam int COUNT_W   = 6;
  localparam int COUNT_MAX = 63;

  // bucket hash: per-digit residue fold, then reduce
  localparam int DIGIT_W     = 4;
  localparam int HASH_DIGITS = ID_W / DIGIT_W;
  localparam int HASH_STEPS  = 2;
  localparam int HSTEP_W     = $clog2(HASH_STEPS);

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
  localparam logic [STAT_W-1:0] STAT_ABSENT = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL   = 2'd2;

  typedef struct packed {
    logic load;
    logic hash_step;
    logic rd_en;
    logic exec;
    logic clr_wr;
  } hst_cmd_t;

  typedef struct packed {
    logic hash_last;
    logic clr_last;
  } hst_stat_t;

endpackage

@@ rtl/hst_ctrl.sv @@
// hst_ctrl: sequencing state machine for the hashed session table.
// Drives datapath commands (clear, hash, read, execute); uses hst_pkg.
module hst_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  hst_pkg::hst_stat_t stat,
  output hst_pkg::hst_cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_HASH  = 5'b00100,
    S_READ  = 5'b01000,
    S_EXEC  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (stat.clr_last) state_nxt = S_IDLE;
      S_IDLE:  if (start) state_nxt = S_HASH;
      S_HASH:  if (stat.hash_last) state_nxt = S_READ;
      S_READ:  state_nxt = S_EXEC;
      S_EXEC:  state_nxt = S_IDLE;
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy          = (state_r != S_IDLE);
  assign cmd.load      = (state_r == S_IDLE) && start;
  assign cmd.hash_step = (state_r == S_HASH);
  assign cmd.rd_en     = (state_r == S_READ);
  assign cmd.exec      = (state_r == S_EXEC);
  assign cmd.clr_wr    = (state_r == S_CLEAR);

  // each accept is followed by execute after the hash and read states
  a_load_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> ##(hst_pkg::HASH_STEPS + 2) cmd.exec)
    else $error("execute not reached at fixed latency after accept");

  a_exec_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> !busy)
    else $error("controller not ready after execute");

endmodule

@@ rtl/hst_dp.sv @@
// hst_dp: datapath of the hashed session table.
// Bucket hash unit, bucket row memory, way compare/update, count and result regs.
// Depends on hst_pkg; commanded by hst_ctrl.
module hst_dp #(
  parameter int BUCKETS = hst_pkg::DEF_BUCKETS,
  parameter int WAYS    = hst_pkg::DEF_WAYS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  hst_pkg::hst_cmd_t             cmd,
  output hst_pkg::hst_stat_t            stat,
  input  logic [hst_pkg::CMD_W-1:0]     in_command,
  input  logic [hst_pkg::ID_W-1:0]      in_id,
  output logic                          out_valid,
  output logic                          out_was_present,
  output logic [hst_pkg::STAT_W-1:0]    out_status,
  output logic [hst_pkg::COUNT_W-1:0]   out_live_count
);

  localparam int ID_W    = hst_pkg::ID_W;
  localparam int BKT_W   = $clog2(BUCKETS);
  localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int SLOTS   = BUCKETS * WAYS;
  localparam int CNT_W   = $clog2(SLOTS + 1);
  localparam int EXT_W   = CNT_W + hst_pkg::COUNT_W;
  localparam int ROW_W   = WAYS * (ID_W + 1);
  localparam int DIG_W   = hst_pkg::DIGIT_W;
  localparam int N_DIG   = hst_pkg::HASH_DIGITS;
  localparam int FOLD_SH = $clog2(hst_pkg::HASH_DIGITS);
  localparam int FOLD_W  = BKT_W + FOLD_SH;

  // residue of digit value val at digit position pos
  function automatic int digit_res(int pos, int val);
    int pw;
    pw = 1 % BUCKETS;
    for (int k = 0; k < pos; k++) pw = (pw * (1 << DIG_W)) % BUCKETS;
    return (val * pw) % BUCKETS;
  endfunction

  logic [hst_pkg::CMD_W-1:0]   cmd_r;
  logic [ID_W-1:0]             id_r;
  logic [BKT_W-1:0]            rem_r, rem_nxt;
  logic [hst_pkg::HSTEP_W-1:0] hstep_r;
  logic [BKT_W-1:0]            clr_addr_r;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;

  logic [N_DIG-1:0][BKT_W-1:0] dig_res;
  logic [FOLD_W-1:0]           fold_sum, fold_r;

  logic [ROW_W-1:0]            mem [BUCKETS];
  logic [ROW_W-1:0]            rd_row_r;
  logic                        mem_we;
  logic [BKT_W-1:0]            mem_addr;
  logic [ROW_W-1:0]            mem_wdata;

  logic [WAYS-1:0]             rd_vld, vld_nxt;
  logic [WAYS-1:0][ID_W-1:0]   rd_ids, ids_nxt;
  logic                        hit_any, free_any;
  logic [WAY_W-1:0]            hit_way, free_way;
  logic [hst_pkg::STAT_W-1:0]  status_nxt;
  logic [EXT_W-1:0]            cnt_ext;
  logic [hst_pkg::COUNT_W-1:0] shown;

  // remainder by BUCKETS: constant residue table per id digit
  for (genvar k = 0; k < N_DIG; k++) begin : g_digit
    logic [(1 << DIG_W)-1:0][BKT_W-1:0] lut;
    for (genvar v = 0; v < (1 << DIG_W); v++) begin : g_ent
      localparam int RES = digit_res(k, v);
      assign lut[v] = BKT_W'(RES);
    end
    assign dig_res[k] = lut[id_r[k*DIG_W +: DIG_W]];
  end

  always_comb begin
    fold_sum = '0;
    for (int k = 0; k < N_DIG; k++) fold_sum = fold_sum + FOLD_W'(dig_res[k]);
  end

  // folded sum is below HASH_DIGITS * BUCKETS
  always_comb begin
    logic [FOLD_W-1:0] acc;
    acc = fold_r;
    for (int j = FOLD_SH - 1; j >= 0; j--) begin
      if (acc >= (FOLD_W'(BUCKETS) << j)) acc = acc - (FOLD_W'(BUCKETS) << j);
    end
    rem_nxt = acc[BKT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r <= in_command;
      id_r  <= in_id;
    end else if (cmd.hash_step) begin
      if (stat.hash_last) rem_r <= rem_nxt;
      else fold_r <= fold_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hstep_r    <= '0;
      clr_addr_r <= '0;
    end else begin
      if (cmd.load) hstep_r <= '0;
      else if (cmd.hash_step) hstep_r <= hstep_r + 1'b1;
      if (cmd.clr_wr) clr_addr_r <= clr_addr_r + 1'b1;
    end
  end

  assign stat.hash_last = (hstep_r == hst_pkg::HSTEP_W'(hst_pkg::HASH_STEPS - 1));
  assign stat.clr_last  = (clr_addr_r == BKT_W'(BUCKETS - 1));

  // bucket rows: {valid bits, ids}
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    if (cmd.rd_en) rd_row_r <= mem[rem_r];
  end

  assign rd_vld = rd_row_r[ROW_W-1 -: WAYS];
  assign rd_ids = rd_row_r[WAYS*ID_W-1:0];

  always_comb begin
    hit_any  = 1'b0;
    hit_way  = '0;
    free_any = 1'b0;
    free_way = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (!hit_any && rd_vld[w] && (rd_ids[w] == id_r)) begin
        hit_any = 1'b1;
        hit_way = WAY_W'(w);
      end
      if (!free_any && !rd_vld[w]) begin
        free_any = 1'b1;
        free_way = WAY_W'(w);
      end
    end
  end

  always_comb begin
    vld_nxt    = rd_vld;
    ids_nxt    = rd_ids;
    cnt_nxt    = cnt_r;
    status_nxt = hst_pkg::STAT_OK;
    case (cmd_r)
      hst_pkg::CMD_INSERT: begin
        if (free_any) begin
          vld_nxt[free_way] = 1'b1;
          ids_nxt[free_way] = id_r;
          cnt_nxt           = cnt_r + 1'b1;
        end else begin
          status_nxt = hst_pkg::STAT_FULL;
        end
      end
      hst_pkg::CMD_REMOVE: begin
        if (hit_any) begin
          vld_nxt[hit_way] = 1'b0;
          ids_nxt[hit_way] = '0;
          cnt_nxt          = cnt_r - 1'b1;
        end else begin
          status_nxt = hst_pkg::STAT_ABSENT;
        end
      end
      default: status_nxt = hst_pkg::STAT_OK;
    endcase
  end

  assign mem_we    = cmd.clr_wr || cmd.exec;
  assign mem_addr  = cmd.clr_wr ? clr_addr_r : rem_r;
  assign mem_wdata = cmd.clr_wr ? '0 : {vld_nxt, ids_nxt};

  assign cnt_ext = EXT_W'(cnt_nxt);
  assign shown   = (cnt_ext > EXT_W'(hst_pkg::COUNT_MAX)) ?
                   hst_pkg::COUNT_W'(hst_pkg::COUNT_MAX) : cnt_ext[hst_pkg::COUNT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.exec;
      if (cmd.exec) cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_was_present <= hit_any;
      out_status      <= status_nxt;
      out_live_count  <= shown;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(SLOTS))
    else $error("entry count beyond table size");

  a_insert_inc: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && cmd_r == hst_pkg::CMD_INSERT && free_any) |=>
      cnt_r == CNT_W'($past(cnt_r) + 1'b1))
    else $error("insert did not bump entry count");

  a_remove_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && cmd_r == hst_pkg::CMD_REMOVE && hit_any) |=>
      cnt_r == CNT_W'($past(cnt_r) - 1'b1))
    else $error("remove did not drop entry count");

endmodule

@@ rtl/hashed_session_table.sv @@
// hashed_session_table: bucketed table of session ids, WAYS slots per bucket.
// Each accepted transaction passes the bucket hash (digit residue fold, then
// reduce), the row read and the execute/write-back state; out_valid is
// registered from execute. start is only sampled in the idle state, so a new
// transaction waits while busy is high. Results cannot stall.
// Reset: after rst_n the bucket memory is cleared over BUCKETS cycles, busy high.
module hashed_session_table #(
  parameter int BUCKETS = hst_pkg::DEF_BUCKETS,
  parameter int WAYS    = hst_pkg::DEF_WAYS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [hst_pkg::CMD_W-1:0]     in_command,
  input  logic [hst_pkg::ID_W-1:0]      in_id,
  output logic                          out_valid,
  output logic                          out_was_present,
  output logic [hst_pkg::STAT_W-1:0]    out_status,
  output logic [hst_pkg::COUNT_W-1:0]   out_live_count
);

  hst_pkg::hst_cmd_t  cmd;
  hst_pkg::hst_stat_t stat;

  hst_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  hst_dp #(
    .BUCKETS (BUCKETS),
    .WAYS    (WAYS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_command      (in_command),
    .in_id           (in_id),
    .out_valid       (out_valid),
    .out_was_present (out_was_present),
    .out_status      (out_status),
    .out_live_count  (out_live_count)
  );

endmodule
